/* sv/lss_pkg.sv */
// Shared types, constants and helper functions for the line substring selector.
package lss_pkg;

  localparam int NEEDLE_BYTES = 16;

  localparam logic [7:0] CH_CR  = 8'd13;
  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_NUL = 8'd0;

  localparam logic [2:0] REG_NEEDLE_LO  = 3'd0;
  localparam logic [2:0] REG_NEEDLE_HI  = 3'd1;
  localparam logic [2:0] REG_NEEDLE_LEN = 3'd2;
  localparam logic [2:0] REG_INVERT     = 3'd3;
  localparam logic [2:0] REG_COUNT_ONLY = 3'd4;

  localparam logic REC_LINE  = 1'b0;
  localparam logic REC_FINAL = 1'b1;

  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } in_beat_t;

  typedef struct packed {
    logic        record_kind;
    logic [31:0] line_count;
    logic        line_selected;
    logic [6:0]  searched_length;
    logic [31:0] selected_total;
    logic        any_found;
  } out_beat_t;

  // Needle as seen by the matcher: pat[j] is the folded needle byte that
  // must line up with the j-th newest window byte.
  typedef struct packed {
    logic [NEEDLE_BYTES-1:0][7:0] pat;
    logic [4:0]                   len;
    logic                         invert;
    logic                         count_only;
  } match_cfg_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'd97 && c <= 8'd122) r = c - 8'd32;
    return r;
  endfunction

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    logic [31:0] r;
    r = v;
    if (v != CNT_MAX) r = v + 32'd1;
    return r;
  endfunction

endpackage

/* sv/lss_cfg_regs.sv */
// Configuration registers and needle alignment for the matcher.
module lss_cfg_regs #(
  parameter int WIN = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_data,
  output lss_pkg::match_cfg_t mcfg
);

  logic [63:0] needle_lo;
  logic [63:0] needle_hi;
  logic [4:0]  needle_len;
  logic        invert;
  logic        count_only;

  always_ff @(posedge clk) begin
    if (rst) begin
      needle_lo  <= '0;
      needle_hi  <= '0;
      needle_len <= '0;
      invert     <= 1'b0;
      count_only <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lss_pkg::REG_NEEDLE_LO:  needle_lo  <= cfg_data;
        lss_pkg::REG_NEEDLE_HI:  needle_hi  <= cfg_data;
        lss_pkg::REG_NEEDLE_LEN: needle_len <= cfg_data[4:0];
        lss_pkg::REG_INVERT:     invert     <= cfg_data[0];
        lss_pkg::REG_COUNT_ONLY: count_only <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [lss_pkg::NEEDLE_BYTES-1:0][7:0] needle;
  logic [4:0] cap_len;
  logic [4:0] eff_len;

  assign needle  = {needle_hi, needle_lo};
  assign cap_len = (needle_len > 5'(WIN)) ? 5'(WIN) : needle_len;

  // needle stops at its first NUL
  always_comb begin
    eff_len = cap_len;
    for (int i = lss_pkg::NEEDLE_BYTES - 1; i >= 0; i--) begin
      if (5'(i) < cap_len && needle[i] == lss_pkg::CH_NUL) eff_len = 5'(i);
    end
  end

  // reverse so the last needle byte lines up with the newest window byte
  always_comb begin
    logic [4:0] idx;
    idx = '0;
    for (int j = 0; j < lss_pkg::NEEDLE_BYTES; j++) begin
      idx = eff_len - 5'd1 - 5'(j);
      mcfg.pat[j] = (5'(j) < eff_len) ? lss_pkg::fold_case(needle[idx[3:0]]) : 8'd0;
    end
    mcfg.len        = eff_len;
    mcfg.invert     = invert;
    mcfg.count_only = count_only;
  end

endmodule

/* sv/lss_engine.sv */
// Per-byte line state, window compare, counters and record build.
module lss_engine #(
  parameter int WIN      = 16,
  parameter int LINE_MAX = 126
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  lss_pkg::in_beat_t   beat,
  input  lss_pkg::match_cfg_t mcfg,
  output logic                rec_wr,
  output lss_pkg::out_beat_t  rec
);

  localparam int SLW = $clog2(LINE_MAX + 1);
  localparam int CW  = (SLW + 1 > 5) ? SLW + 1 : 5;

  logic [WIN-1:0][7:0] win;
  logic [SLW-1:0]      stored_len;
  logic                nul_seen;
  logic                line_hit;
  logic                after_cr;
  logic [31:0]         line_counter;
  logic [31:0]         match_counter;
  logic                found_flag;

  logic [WIN-1:0][7:0] win_next;
  logic [SLW-1:0]      stored_len_next;
  logic                nul_seen_next;
  logic                line_hit_next;
  logic                after_cr_next;
  logic [31:0]         line_counter_next;
  logic [31:0]         match_counter_next;
  logic                found_flag_next;

  logic [WIN-1:0][7:0] win_shift;
  logic [WIN-1:0]      lane_ok;
  logic                long_enough;
  logic                hit_now;
  logic                sel;
  logic                ended;
  logic                final_rec;
  logic                emit;
  logic [7:0]          c;

  assign c = beat.data_byte;

  always_comb begin
    win_shift[0] = c;
    for (int j = 1; j < WIN; j++) win_shift[j] = win[j-1];
  end

  always_comb begin
    for (int j = 0; j < WIN; j++) begin
      lane_ok[j] = (5'(j) >= mcfg.len) ||
                   (lss_pkg::fold_case(win_shift[j]) == mcfg.pat[j]);
    end
  end

  assign long_enough = (CW'(stored_len) + CW'(1)) >= CW'(mcfg.len);
  assign hit_now     = long_enough && (&lane_ok);
  assign sel         = line_hit ^ mcfg.invert;

  always_comb begin
    win_next           = win;
    stored_len_next    = stored_len;
    nul_seen_next      = nul_seen;
    line_hit_next      = line_hit;
    after_cr_next      = after_cr;
    line_counter_next  = line_counter;
    match_counter_next = match_counter;
    found_flag_next    = found_flag;
    ended              = 1'b0;
    final_rec          = 1'b0;
    emit               = 1'b0;

    if (beat.end_of_input) begin
      ended         = (stored_len != '0);
      final_rec     = mcfg.count_only;
      emit          = mcfg.count_only || ended;
      after_cr_next = 1'b0;
    end else if (c == lss_pkg::CH_CR) begin
      ended         = 1'b1;
      emit          = !mcfg.count_only;
      after_cr_next = 1'b1;
    end else if (c == lss_pkg::CH_LF) begin
      ended         = !after_cr;
      emit          = ended && !mcfg.count_only;
      after_cr_next = 1'b0;
    end else begin
      after_cr_next = 1'b0;
      if (stored_len < SLW'(LINE_MAX)) begin
        if (c == lss_pkg::CH_NUL) begin
          nul_seen_next = 1'b1;
        end else if (!nul_seen) begin
          win_next = win_shift;
          if (hit_now) line_hit_next = 1'b1;
        end
        stored_len_next = stored_len + SLW'(1);
      end
    end

    if (ended) begin
      line_counter_next = lss_pkg::sat_inc(line_counter);
      if (sel) begin
        match_counter_next = lss_pkg::sat_inc(match_counter);
        found_flag_next    = 1'b1;
      end
    end

    // end of input always drops the line, as does any line end
    if (ended || beat.end_of_input) begin
      win_next        = '0;
      stored_len_next = '0;
      nul_seen_next   = 1'b0;
      line_hit_next   = 1'b0;
    end
  end

  assign rec_wr              = take && emit;
  assign rec.record_kind     = final_rec ? lss_pkg::REC_FINAL : lss_pkg::REC_LINE;
  assign rec.line_count      = line_counter_next;
  assign rec.line_selected   = final_rec ? 1'b0 : sel;
  assign rec.searched_length = final_rec ? 7'd0 : 7'(stored_len);
  assign rec.selected_total  = match_counter_next;
  assign rec.any_found       = found_flag_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      win           <= '0;
      stored_len    <= '0;
      nul_seen      <= 1'b0;
      line_hit      <= 1'b0;
      after_cr      <= 1'b0;
      line_counter  <= '0;
      match_counter <= '0;
      found_flag    <= 1'b0;
    end else if (take) begin
      win           <= win_next;
      stored_len    <= stored_len_next;
      nul_seen      <= nul_seen_next;
      line_hit      <= line_hit_next;
      after_cr      <= after_cr_next;
      line_counter  <= line_counter_next;
      match_counter <= match_counter_next;
      found_flag    <= found_flag_next;
    end
  end

  a_eoi_clears: assert property (@(posedge clk) disable iff (rst)
    take && beat.end_of_input |=> stored_len == '0 && !after_cr && !line_hit)
    else $error("line state not cleared at end of input");

  a_match_le_line: assert property (@(posedge clk) disable iff (rst)
    match_counter <= line_counter)
    else $error("selected count exceeds line count");

  a_found_flag: assert property (@(posedge clk) disable iff (rst)
    found_flag == (match_counter != '0))
    else $error("found flag out of step with selected count");

  a_line_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> line_counter >= $past(line_counter))
    else $error("line counter went backward");

endmodule

/* sv/lss_rec_queue.sv */
// Two-entry record queue between the engine and the output channel.
module lss_rec_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr,
  input  lss_pkg::out_beat_t wdata,
  output logic               space,
  output logic               rec_valid,
  input  logic               rec_ready,
  output lss_pkg::out_beat_t rec_data
);

  lss_pkg::out_beat_t q [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] count;
  logic       pop;

  assign space     = (count != 2'd2);
  assign rec_valid = (count != 2'd0);
  assign rec_data  = q[rd_ptr];
  assign pop       = rec_valid && rec_ready;

  always_ff @(posedge clk) begin
    if (wr) q[wr_ptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr)  wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(wr) - 2'(pop);
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    wr |-> count != 2'd2)
    else $error("record written into full queue");

endmodule

/* sv/line_substring_selector_core.sv */
// Top level: input register, config registers, line engine and record queue.
//
// Byte channel (byte_valid/byte_ready/byte_data) carries one text byte or an
// end-of-input mark per beat. Record channel (rec_valid/rec_ready/rec_data)
// carries per-line records or, in count mode, only a final summary record.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data); the user
// must write it only while the block is idle, which the block does not enforce.
//
// Throughput: one byte per cycle while the record queue has space. An accepted
// beat is held in the input register while the line engine folds it into the
// line state; a record it ends is pushed into a two-entry queue and is offered
// on rec_data from there.
//
// Reset clears the config registers, line state, window and counters to
// zero; no clearing pass is needed and bytes are taken right after reset.
// When the receiver stalls, records collect in the queue and bytes keep
// flowing; byte_ready drops only once the queue holds two records and the
// input register is occupied.
module line_substring_selector_core #(
  parameter int NEEDLE_MAX = 16,
  parameter int LINE_MAX   = 126
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               byte_ready,
  input  lss_pkg::in_beat_t  byte_data,
  output logic               rec_valid,
  input  logic               rec_ready,
  output lss_pkg::out_beat_t rec_data,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data
);

  localparam int WIN = (NEEDLE_MAX < lss_pkg::NEEDLE_BYTES) ? NEEDLE_MAX
                                                             : lss_pkg::NEEDLE_BYTES;

  logic                held_valid;
  lss_pkg::in_beat_t   held;
  logic                space;
  logic                take;
  logic                rec_wr;
  lss_pkg::out_beat_t  rec;
  lss_pkg::match_cfg_t mcfg;

  assign take       = held_valid && space;
  assign byte_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (byte_valid && byte_ready) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && byte_ready) held <= byte_data;
  end

  lss_cfg_regs #(
    .WIN(WIN)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mcfg      (mcfg)
  );

  lss_engine #(
    .WIN      (WIN),
    .LINE_MAX (LINE_MAX)
  ) u_engine (
    .clk    (clk),
    .rst    (rst),
    .take   (take),
    .beat   (held),
    .mcfg   (mcfg),
    .rec_wr (rec_wr),
    .rec    (rec)
  );

  lss_rec_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr        (rec_wr),
    .wdata     (rec),
    .space     (space),
    .rec_valid (rec_valid),
    .rec_ready (rec_ready),
    .rec_data  (rec_data)
  );

endmodule

/* sim/tb_top.sv */
// Testbench for line_substring_selector_core: directed table, random line traffic, scoreboard.
module tb_top;

  localparam int NEEDLE_MAX    = 16;
  localparam int LINE_MAX      = 126;
  localparam int SETTLE        = 6;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 24;

  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_REC} check_t;
  typedef enum logic {ROW_BYTE, ROW_REG} row_t;

  typedef struct packed {
    row_t                op;
    logic [2:0]          idx;
    logic [63:0]         value;
    lss_pkg::in_beat_t   beat;
    check_t              chk;
    lss_pkg::out_beat_t  rec;
  } plan_row_t;

  logic               clk;
  logic               rst        = 1'b1;
  logic               byte_valid = 1'b0;
  logic               byte_ready;
  lss_pkg::in_beat_t  byte_data  = '0;
  logic               rec_valid;
  logic               rec_ready  = 1'b0;
  lss_pkg::out_beat_t rec_data;
  logic               cfg_we     = 1'b0;
  logic [2:0]         cfg_index  = lss_pkg::REG_NEEDLE_LO;
  logic [63:0]        cfg_data   = '0;

  // how the scoreboard treats the beat currently offered
  check_t             pin_chk = CHK_MODEL;
  lss_pkg::out_beat_t pin_rec = '0;

  int    gap_pct      = 0;
  int    stall_pct    = 0;
  int    sent_items   = 0;
  int    fail_count   = 0;
  int    records_seen = 0;
  int    cycle_count  = 0;
  string text_set     = "abcAB x1";

  // grep state mirrored by the testbench
  logic [63:0]                  nd_lo      = '0;
  logic [63:0]                  nd_hi      = '0;
  logic [4:0]                   nd_len     = '0;
  logic                         inv_sel    = 1'b0;
  logic                         count_mode = 1'b0;
  logic [NEEDLE_MAX-1:0][7:0]   window     = '0;
  logic [6:0]                   line_len   = '0;
  logic                         nul_hit    = 1'b0;
  logic                         line_hit   = 1'b0;
  logic                         after_cr   = 1'b0;
  logic [31:0]                  lines_seen   = '0;
  logic [31:0]                  lines_picked = '0;
  logic                         found_any    = 1'b0;
  lss_pkg::out_beat_t           awaited_records[$];

  line_substring_selector_core #(
    .NEEDLE_MAX(NEEDLE_MAX),
    .LINE_MAX  (LINE_MAX)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .byte_valid(byte_valid),
    .byte_ready(byte_ready),
    .byte_data (byte_data),
    .rec_valid (rec_valid),
    .rec_ready (rec_ready),
    .rec_data  (rec_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [7:0] upcase(logic [7:0] c);
    if (c >= "a" && c <= "z") return c - 8'd32;
    return c;
  endfunction

  function automatic logic [7:0] needle_at(int i);
    if (i < 8) return nd_lo[8*i +: 8];
    if (i < 16) return nd_hi[8*(i-8) +: 8];
    return 8'h00;
  endfunction

  // usable needle: length clipped to the window, cut at the first NUL
  function automatic int needle_span();
    int n;
    n = nd_len;
    if (n > NEEDLE_MAX) n = NEEDLE_MAX;
    if (n > 16) n = 16;
    for (int i = 0; i < n; i++)
      if (needle_at(i) == lss_pkg::CH_NUL) return i;
    return n;
  endfunction

  function automatic lss_pkg::out_beat_t make_rec(logic kind, logic [31:0] n, logic sel,
                                                  logic [6:0] len, logic [31:0] tot,
                                                  logic f);
    lss_pkg::out_beat_t r;
    r.record_kind     = kind;
    r.line_count      = n;
    r.line_selected   = sel;
    r.searched_length = len;
    r.selected_total  = tot;
    r.any_found       = f;
    return r;
  endfunction

  function automatic void clear_line();
    window   = '0;
    line_len = '0;
    nul_hit  = 1'b0;
    line_hit = 1'b0;
  endfunction

  function automatic void shift_in(logic [7:0] c);
    int   span;
    logic same;
    span   = needle_span();
    window = {window[NEEDLE_MAX-2:0], c};
    if (line_len + 1 >= span) begin
      same = 1'b1;
      for (int i = 0; i < span; i++)
        if (upcase(needle_at(i)) != upcase(window[span-1-i])) same = 1'b0;
      if (same) line_hit = 1'b1;
    end
  endfunction

  function automatic bit close_line(output lss_pkg::out_beat_t r);
    logic sel;
    sel = line_hit ^ inv_sel;
    if (lines_seen != lss_pkg::CNT_MAX) lines_seen++;
    if (sel) begin
      found_any = 1'b1;
      if (lines_picked != lss_pkg::CNT_MAX) lines_picked++;
    end
    r = make_rec(lss_pkg::REC_LINE, lines_seen, sel, line_len, lines_picked, found_any);
    clear_line();
    return !count_mode;
  endfunction

  function automatic bit grep_step(lss_pkg::in_beat_t b, output lss_pkg::out_beat_t r);
    bit got;
    got = 1'b0;
    r   = '0;
    if (b.end_of_input) begin
      if (line_len != 0) got = close_line(r);
      clear_line();
      after_cr = 1'b0;
      if (count_mode) begin
        r   = make_rec(lss_pkg::REC_FINAL, lines_seen, 1'b0, 7'd0, lines_picked,
                       found_any);
        got = 1'b1;
      end
    end else if (b.data_byte == lss_pkg::CH_CR) begin
      got      = close_line(r);
      after_cr = 1'b1;
    end else if (b.data_byte == lss_pkg::CH_LF) begin
      if (!after_cr) got = close_line(r);
      after_cr = 1'b0;
    end else begin
      after_cr = 1'b0;
      // bytes past the line cap are dropped
      if (line_len < LINE_MAX) begin
        if (b.data_byte == lss_pkg::CH_NUL) nul_hit = 1'b1;
        else if (!nul_hit) shift_in(b.data_byte);
        line_len++;
      end
    end
    return got;
  endfunction

  function automatic string show(lss_pkg::out_beat_t r);
    return $sformatf("kind=%0d line=%0d sel=%0d len=%0d total=%0d found=%0d",
                     r.record_kind, r.line_count, r.line_selected, r.searched_length,
                     r.selected_total, r.any_found);
  endfunction

  function automatic plan_row_t byte_row(logic [7:0] c, logic eoi, check_t chk,
                                         lss_pkg::out_beat_t r);
    plan_row_t p;
    p                   = '0;
    p.op                = ROW_BYTE;
    p.beat.data_byte    = c;
    p.beat.end_of_input = eoi;
    p.chk               = chk;
    p.rec               = r;
    return p;
  endfunction

  function automatic plan_row_t reg_row(logic [2:0] idx, logic [63:0] v);
    plan_row_t p;
    p       = '0;
    p.op    = ROW_REG;
    p.idx   = idx;
    p.value = v;
    return p;
  endfunction

  task automatic note_fail(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  task automatic send_beat(lss_pkg::in_beat_t b, check_t chk, lss_pkg::out_beat_t r);
    while ($urandom_range(99) < gap_pct) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_data  <= b;
    pin_chk    <= chk;
    pin_rec    <= r;
    @(posedge clk);
    while (!byte_ready) @(posedge clk);
    sent_items++;
  endtask

  task automatic send_text(logic [7:0] c);
    lss_pkg::in_beat_t b;
    b.data_byte    = c;
    b.end_of_input = 1'b0;
    send_beat(b, CHK_MODEL, '0);
  endtask

  task automatic send_end();
    lss_pkg::in_beat_t b;
    b.data_byte    = 8'($urandom_range(255));
    b.end_of_input = 1'b1;
    send_beat(b, CHK_MODEL, '0);
  endtask

  // sender holds off until every awaited record is out and the pipe is quiet
  task automatic drain_records();
    byte_valid <= 1'b0;
    @(negedge clk);
    while (awaited_records.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    unique case (idx)
      lss_pkg::REG_NEEDLE_LO:  nd_lo      = v;
      lss_pkg::REG_NEEDLE_HI:  nd_hi      = v;
      lss_pkg::REG_NEEDLE_LEN: nd_len     = v[4:0];
      lss_pkg::REG_INVERT:     inv_sel    = v[0];
      lss_pkg::REG_COUNT_ONLY: count_mode = v[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic new_setting(int ph);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [4:0]  len;
    logic [7:0]  c;
    int          cut;
    lo = '0;
    hi = '0;
    for (int k = 0; k < 16; k++) begin
      c = text_set[$urandom_range(text_set.len() - 1)];
      if (k < 8) lo[8*k +: 8] = c;
      else hi[8*(k-8) +: 8] = c;
    end
    if (ph == 5) begin
      cut = $urandom_range(2);
      lo[8*cut +: 8] = lss_pkg::CH_NUL;
    end
    unique case (ph)
      0: len = 5'd3;
      1: len = 5'd16;
      2: len = 5'd0;
      3: len = 5'd31;
      default: len = 5'($urandom_range(1, 5));
    endcase
    write_reg(lss_pkg::REG_NEEDLE_LO, lo);
    write_reg(lss_pkg::REG_NEEDLE_HI, hi);
    write_reg(lss_pkg::REG_NEEDLE_LEN, 64'(len));
    write_reg(lss_pkg::REG_INVERT, 64'(ph % 2));
    write_reg(lss_pkg::REG_COUNT_ONLY, 64'(ph == 2 || ph == 6));
  endtask

  function automatic logic [7:0] mix_case(logic [7:0] c);
    if (upcase(c) >= "A" && upcase(c) <= "Z" && $urandom_range(1)) return c ^ 8'h20;
    return c;
  endfunction

  function automatic logic [7:0] filler();
    int p;
    p = $urandom_range(99);
    if (p < 70) return text_set[$urandom_range(text_set.len() - 1)];
    if (p < 76) return lss_pkg::CH_NUL;
    return 8'($urandom_range(14, 255));
  endfunction

  // one line of text, needle planted at a random spot half the time
  task automatic send_line(bit overlong);
    int body;
    int spot;
    int span;
    int pick;
    span = needle_span();
    body = overlong ? $urandom_range(124, 134) : $urandom_range(0, 10);
    spot = $urandom_range(1) ? $urandom_range(0, body) : -1;
    for (int i = 0; i <= body; i++) begin
      if (i == spot)
        for (int j = 0; j < span; j++) send_text(mix_case(needle_at(j)));
      if (i < body) send_text(filler());
    end
    pick = $urandom_range(99);
    if (count_mode && $urandom_range(3) == 0) send_end();
    else if (pick < 40) send_text(lss_pkg::CH_LF);
    else if (pick < 62) send_text(lss_pkg::CH_CR);
    else if (pick < 84) begin
      send_text(lss_pkg::CH_CR);
      send_text(lss_pkg::CH_LF);
    end else if (pick < 92) begin
      send_text(lss_pkg::CH_LF);
      send_text(lss_pkg::CH_CR);
    end else send_end();
  endtask

  task automatic send_noise();
    if ($urandom_range(3) == 0) send_end();
    else send_text(8'($urandom_range(255)));
  endtask

  always @(posedge clk) rec_ready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin : scoreboard
    lss_pkg::out_beat_t made;
    lss_pkg::out_beat_t want;
    bit                 produced;
    if (!rst) begin
      if (byte_valid && byte_ready) begin
        produced = grep_step(byte_data, made);
        if (pin_chk == CHK_REC) awaited_records.push_back(pin_rec);
        else if (pin_chk == CHK_MODEL && produced) awaited_records.push_back(made);
      end
      if (rec_valid && rec_ready) begin
        records_seen++;
        if (awaited_records.size() == 0) begin
          note_fail($sformatf("record %0d unexpected: %s", records_seen, show(rec_data)));
        end else begin
          want = awaited_records.pop_front();
          if (rec_data.record_kind     !== want.record_kind     ||
              rec_data.line_count      !== want.line_count      ||
              rec_data.line_selected   !== want.line_selected   ||
              rec_data.searched_length !== want.searched_length ||
              rec_data.selected_total  !== want.selected_total  ||
              rec_data.any_found       !== want.any_found)
            note_fail($sformatf("record %0d mismatch: expected %s, got %s",
                                records_seen, show(want), show(rec_data)));
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    plan_row_t          plan[$];
    lss_pkg::out_beat_t none;
    logic               writing;
    int                 phase_end;
    int                 guard;
    none    = '0;
    writing = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    gap_pct   = 28;
    stall_pct = 28;

    // reset config: empty needle matches any line with searchable text
    plan.push_back(byte_row("a", 1'b0, CHK_NONE, none));
    plan.push_back(byte_row(lss_pkg::CH_CR, 1'b0, CHK_REC,
                            make_rec(lss_pkg::REC_LINE, 32'd1, 1'b1, 7'd1, 32'd1, 1'b1)));
    plan.push_back(byte_row(lss_pkg::CH_LF, 1'b0, CHK_NONE, none));
    plan.push_back(byte_row(lss_pkg::CH_LF, 1'b0, CHK_REC,
                            make_rec(lss_pkg::REC_LINE, 32'd2, 1'b0, 7'd0, 32'd1, 1'b1)));
    plan.push_back(byte_row(lss_pkg::CH_NUL, 1'b0, CHK_NONE, none));
    plan.push_back(byte_row("x", 1'b0, CHK_NONE, none));
    plan.push_back(byte_row(lss_pkg::CH_LF, 1'b0, CHK_REC,
                            make_rec(lss_pkg::REC_LINE, 32'd3, 1'b0, 7'd2, 32'd1, 1'b1)));
    plan.push_back(byte_row(8'h00, 1'b1, CHK_NONE, none));
    // needle "Ab" then NUL, length above the max
    plan.push_back(reg_row(lss_pkg::REG_NEEDLE_LO, 64'h5A5A_5A5A_5A00_6241));
    plan.push_back(reg_row(lss_pkg::REG_NEEDLE_HI, 64'hFFFF_FFFF_FFFF_FFFF));
    plan.push_back(reg_row(lss_pkg::REG_NEEDLE_LEN, 64'd31));
    plan.push_back(byte_row("a", 1'b0, CHK_MODEL, none));
    plan.push_back(byte_row("B", 1'b0, CHK_MODEL, none));
    plan.push_back(byte_row(lss_pkg::CH_CR, 1'b0, CHK_MODEL, none));
    plan.push_back(byte_row("x", 1'b0, CHK_MODEL, none));
    plan.push_back(byte_row(8'h5A, 1'b1, CHK_MODEL, none));
    // inverted, count mode: only final beats come back
    plan.push_back(reg_row(lss_pkg::REG_INVERT, 64'd1));
    plan.push_back(reg_row(lss_pkg::REG_COUNT_ONLY, 64'd1));
    plan.push_back(byte_row("q", 1'b0, CHK_NONE, none));
    plan.push_back(byte_row(lss_pkg::CH_CR, 1'b0, CHK_NONE, none));
    plan.push_back(byte_row(8'hFF, 1'b0, CHK_NONE, none));
    plan.push_back(byte_row(8'hFF, 1'b1, CHK_MODEL, none));
    plan.push_back(byte_row(8'h00, 1'b1, CHK_MODEL, none));
    // all-zero needle of full length acts as empty
    plan.push_back(reg_row(lss_pkg::REG_NEEDLE_LO, 64'd0));
    plan.push_back(reg_row(lss_pkg::REG_NEEDLE_HI, 64'd0));
    plan.push_back(reg_row(lss_pkg::REG_NEEDLE_LEN, 64'd16));
    plan.push_back(reg_row(lss_pkg::REG_INVERT, 64'd0));
    plan.push_back(reg_row(lss_pkg::REG_COUNT_ONLY, 64'd0));
    plan.push_back(byte_row(lss_pkg::CH_LF, 1'b0, CHK_MODEL, none));
    plan.push_back(byte_row(lss_pkg::CH_CR, 1'b0, CHK_MODEL, none));
    plan.push_back(byte_row(lss_pkg::CH_CR, 1'b0, CHK_MODEL, none));
    plan.push_back(byte_row(lss_pkg::CH_LF, 1'b0, CHK_NONE, none));
    plan.push_back(byte_row("Z", 1'b0, CHK_MODEL, none));
    plan.push_back(byte_row(8'hA5, 1'b1, CHK_MODEL, none));

    foreach (plan[k]) begin
      if (plan[k].op == ROW_REG) begin
        if (!writing) drain_records();
        writing = 1'b1;
        write_reg(plan[k].idx, plan[k].value);
      end else begin
        if (writing) cfg_we <= 1'b0;
        writing = 1'b0;
        send_beat(plan[k].beat, plan[k].chk, plan[k].rec);
      end
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain_records();
      new_setting(ph);
      cfg_we <= 1'b0;
      unique case (ph % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 64; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 64; end
        default: begin gap_pct = 28; stall_pct = 28; end
      endcase
      phase_end = sent_items + PHASE_ITEMS;
      if (ph == 4 || ph == 7) send_line(1'b1);
      while (sent_items < phase_end) begin
        if ($urandom_range(29) == 0) drain_records();
        if ($urandom_range(9) == 0) send_noise();
        send_line(1'b0);
      end
    end

    byte_valid <= 1'b0;
    guard = 0;
    @(negedge clk);
    while (awaited_records.size() != 0 && guard < 20000) begin
      @(negedge clk);
      guard++;
    end
    repeat (SETTLE) @(negedge clk);
    if (awaited_records.size() != 0)
      note_fail($sformatf("%0d records never arrived", awaited_records.size()));
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* files.f */
sv/lss_pkg.sv
sv/lss_cfg_regs.sv
sv/lss_engine.sv
sv/lss_rec_queue.sv
sv/line_substring_selector_core.sv
sim/tb_top.sv
